### src/ivi_pkg.sv
// shared types and constants of the vertex to cell interpolator
// no dependencies

package ivi_pkg;

   localparam int unsigned FRAC_BITS_DEFAULT = 16;
   localparam int unsigned MAX_VERTS_DEFAULT = 64;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned DIV_NUM_W = 96;
   localparam int unsigned DIV_DEN_W = 64;

   localparam logic CSR_METHOD = 1'b0;
   localparam logic CSR_USE_WEIGHT = 1'b1;

   typedef struct packed {
      logic [31:0] half_x;
      logic [31:0] half_y;
      logic [31:0] half_z;
      logic signed [31:0] value;
      logic [31:0] weight;
      logic last;
      logic shepard;
      logic use_weight;
      logic coincident;
   } item_type;

endpackage

### src/vertex_to_cell_interpolator_core.sv
// top level of the vertex to cell interpolator
// depends on ivi_pkg, ivi_front, ivi_fifo, ivi_back
//
// Vertices of a cell are pushed one per transfer on the req_ queue
// (push/full); the vertex with req_last_vertex set closes the cell and
// yields one result on the rsp_ queue (empty/pop). csr_ writes set the
// method and vertex weighting; each vertex uses the setting of its push.
// A front stage classifies vertices into a four-entry queue; the back
// end works one vertex at a time with one 32x32 multiplier, a 32-step
// square root and a shared divider.
// Inverse distance mode adds a square root and a reciprocal divide per
// vertex not at the centre; closing a cell with a nonzero weight sum adds
// a final divide.
// Reset clears configuration, sums and both queues. When the receiver
// stalls, the result register holds; the back end stops at the next cell
// close and the input queue fills, then full rises.

module vertex_to_cell_interpolator_core import ivi_pkg::*; #(
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEFAULT,
   parameter int unsigned MAX_VERTS_PER_CELL = MAX_VERTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic               csr_write_data,
   input  logic               req_push,
   output logic               req_full,
   input  logic signed [31:0] req_vertex_x,
   input  logic signed [31:0] req_vertex_y,
   input  logic signed [31:0] req_vertex_z,
   input  logic signed [31:0] req_centre_x,
   input  logic signed [31:0] req_centre_y,
   input  logic signed [31:0] req_centre_z,
   input  logic signed [31:0] req_vertex_value,
   input  logic [31:0]        req_vertex_weight,
   input  logic               req_last_vertex,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [31:0] rsp_cell_value,
   output logic               rsp_status
);

   item_type entry, head;
   logic q_pop, q_empty;

   ivi_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_vertex_x     (req_vertex_x),
      .req_vertex_y     (req_vertex_y),
      .req_vertex_z     (req_vertex_z),
      .req_centre_x     (req_centre_x),
      .req_centre_y     (req_centre_y),
      .req_centre_z     (req_centre_z),
      .req_vertex_value (req_vertex_value),
      .req_vertex_weight(req_vertex_weight),
      .req_last_vertex  (req_last_vertex),
      .entry            (entry)
   );

   ivi_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (entry),
      .full      (req_full),
      .pop       (q_pop),
      .head      (head),
      .empty     (q_empty)
   );

   ivi_back #(.FRAC_BITS(FRAC_BITS), .MAX_VERTS(MAX_VERTS_PER_CELL)) u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_cell_value (rsp_cell_value),
      .rsp_status     (rsp_status)
   );

endmodule

### src/ivi_div.sv
// restoring divider, one quotient bit per cycle
// depends on ivi_pkg

module ivi_div import ivi_pkg::*; #(
   parameter int unsigned NUM_W = DIV_NUM_W,
   parameter int unsigned DEN_W = DIV_DEN_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W:0]   rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   rem_sh;
   logic             ge;

   assign rem_sh = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
   assign ge = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quo_ff <= dividend;
            den_ff <= divisor;
            rem_ff <= '0;
            cnt_ff <= CNT_W'(NUM_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= ge ? rem_sh - {1'b0, den_ff} : rem_sh;
            quo_ff <= {quo_ff[NUM_W-2:0], ge};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

### src/ivi_front.sv
// front end: configuration registers and vertex classification
// depends on ivi_pkg

module ivi_front import ivi_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic               csr_write_data,
   input  logic signed [31:0] req_vertex_x,
   input  logic signed [31:0] req_vertex_y,
   input  logic signed [31:0] req_vertex_z,
   input  logic signed [31:0] req_centre_x,
   input  logic signed [31:0] req_centre_y,
   input  logic signed [31:0] req_centre_z,
   input  logic signed [31:0] req_vertex_value,
   input  logic [31:0]        req_vertex_weight,
   input  logic               req_last_vertex,
   output item_type           entry
);

   logic method_ff;
   logic use_weight_ff;
   logic [31:0] hx, hy, hz;
   logic zx, zy, zz;

   function automatic logic [31:0] half_abs(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
      logic signed [32:0] d;
      logic [32:0] m;
      logic [33:0] s;
      d = 33'(a) - 33'(b);
      m = d[32] ? 33'(-d) : 33'(d);
      s = 34'(m) + 34'd1;
      return s[32:1];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff <= 1'b0;
         use_weight_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_METHOD: method_ff <= csr_write_data;
            CSR_USE_WEIGHT: use_weight_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign hx = half_abs(req_vertex_x, req_centre_x);
   assign hy = half_abs(req_vertex_y, req_centre_y);
   assign hz = half_abs(req_vertex_z, req_centre_z);
   assign zx = req_vertex_x == req_centre_x;
   assign zy = req_vertex_y == req_centre_y;
   assign zz = req_vertex_z == req_centre_z;

   always_comb begin
      entry.half_x = hx;
      entry.half_y = hy;
      entry.half_z = hz;
      entry.value = req_vertex_value;
      entry.weight = req_vertex_weight;
      entry.last = req_last_vertex;
      entry.shepard = method_ff;
      entry.use_weight = use_weight_ff;
      entry.coincident = method_ff && zx && zy && zz;
   end

endmodule

### src/ivi_fifo.sv
// short queue of classified vertices between front and back end
// depends on ivi_pkg

module ivi_fifo import ivi_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_data,
   output logic     full,
   input  logic     pop,
   output item_type head,
   output logic     empty
);

   localparam int unsigned PTR_W = $clog2(DEPTH);

   item_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [PTR_W:0]   count_ff;
   logic do_push, do_pop;

   assign full = count_ff == (PTR_W+1)'(DEPTH);
   assign empty = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign head = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         count_ff <= count_ff + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
      end
   end

endmodule

### src/ivi_back.sv
// back end: distance weight, accumulation and final divide per cell
// depends on ivi_pkg and ivi_div

module ivi_back import ivi_pkg::*; #(
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEFAULT,
   parameter int unsigned MAX_VERTS = MAX_VERTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  item_type           head,
   input  logic               q_empty,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [31:0] rsp_cell_value,
   output logic               rsp_status
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLASSIFY, ST_SQUARE, ST_SQRT, ST_INV_GO, ST_INV, ST_SCALE,
      ST_SCALE_SAT, ST_TERM, ST_ACC, ST_CLOSE, ST_FDIV, ST_EMIT
   } state_type;

   localparam logic [31:0] ONE_Q = 32'd1 << FRAC_BITS;
   localparam logic [63:0] ROUND_UP = (64'd1 << FRAC_BITS) - 64'd1;

   state_type state_ff;
   item_type  item_ff;
   logic [1:0]  step_ff;
   logic [63:0] s_ff, rem_ff, root_ff, bit_ff;
   logic [31:0] base_ff, w_ff;
   logic [63:0] prod_ff;
   logic signed [63:0] vsum_ff, csum_ff;
   logic [63:0] wsum_ff, cwsum_ff;
   logic coinc_seen_ff;
   logic [7:0] vcount_ff;
   logic neg_ff;
   logic [DIV_NUM_W-1:0] dividend_ff;
   logic [DIV_DEN_W-1:0] divisor_ff;
   logic div_start_ff;
   logic rsp_valid_ff;
   logic signed [31:0] rsp_value_ff;
   logic rsp_status_ff;
   logic signed [31:0] pend_value_ff;
   logic pend_status_ff;

   logic [31:0] mul_a, mul_b, abs_value;
   logic [63:0] term_mag, scaled, sel_wsum, sel_mag;
   logic signed [63:0] term, sel_vsum;
   logic [DIV_NUM_W-1:0] quo;
   logic div_done;
   logic emit_load;

   ivi_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (dividend_ff),
      .divisor  (divisor_ff),
      .done     (div_done),
      .quotient (quo)
   );

   assign abs_value = item_ff.value[31] ? 32'(-item_ff.value) : 32'(item_ff.value);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SQUARE: begin
            case (step_ff)
               2'd0: mul_a = item_ff.half_x;
               2'd1: mul_a = item_ff.half_y;
               2'd2: mul_a = item_ff.half_z;
               default: mul_a = '0;
            endcase
            mul_b = mul_a;
         end
         ST_SCALE: begin
            mul_a = base_ff;
            mul_b = item_ff.weight;
         end
         ST_TERM: begin
            mul_a = abs_value;
            mul_b = w_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
   end

   assign term_mag = item_ff.value[31] ? ((prod_ff + ROUND_UP) >> FRAC_BITS)
                                       : (prod_ff >> FRAC_BITS);
   assign term = item_ff.value[31] ? -$signed(term_mag) : $signed(term_mag);
   assign scaled = prod_ff >> FRAC_BITS;
   assign sel_vsum = coinc_seen_ff ? csum_ff : vsum_ff;
   assign sel_wsum = coinc_seen_ff ? cwsum_ff : wsum_ff;
   assign sel_mag = sel_vsum[63] ? 64'(-sel_vsum) : 64'(sel_vsum);
   assign q_pop = state_ff == ST_IDLE && !q_empty;
   assign emit_load = state_ff == ST_EMIT && (!rsp_valid_ff || rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
         vsum_ff <= '0;
         csum_ff <= '0;
         wsum_ff <= '0;
         cwsum_ff <= '0;
         coinc_seen_ff <= 1'b0;
         vcount_ff <= '0;
         step_ff <= '0;
      end else begin
         div_start_ff <= 1'b0;
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop && rsp_valid_ff) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  item_ff <= head;
                  state_ff <= ST_CLASSIFY;
               end
            end
            ST_CLASSIFY: begin
               if (vcount_ff >= 8'(MAX_VERTS)) begin
                  state_ff <= ST_CLOSE;
               end else if (item_ff.shepard && !item_ff.coincident) begin
                  s_ff <= '0;
                  step_ff <= '0;
                  state_ff <= ST_SQUARE;
               end else begin
                  base_ff <= ONE_Q;
                  state_ff <= ST_SCALE;
               end
            end
            ST_SQUARE: begin
               if (step_ff != 2'd0) begin
                  s_ff <= s_ff + prod_ff;
               end
               if (step_ff == 2'd3) begin
                  rem_ff <= s_ff + prod_ff;
                  root_ff <= '0;
                  bit_ff <= 64'd1 << 62;
                  state_ff <= ST_SQRT;
               end
               step_ff <= step_ff + 2'd1;
            end
            ST_SQRT: begin
               if (rem_ff >= root_ff + bit_ff) begin
                  rem_ff <= rem_ff - (root_ff + bit_ff);
                  root_ff <= (root_ff >> 1) + bit_ff;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               if (bit_ff[0]) begin
                  state_ff <= ST_INV_GO;
               end
            end
            ST_INV_GO: begin
               dividend_ff <= DIV_NUM_W'(1) << (2 * FRAC_BITS - 1);
               divisor_ff <= (root_ff == '0) ? DIV_DEN_W'(1) : root_ff;
               div_start_ff <= 1'b1;
               state_ff <= ST_INV;
            end
            ST_INV: begin
               if (div_done) begin
                  base_ff <= (|quo[DIV_NUM_W-1:32]) ? '1 : quo[31:0];
                  state_ff <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               if (item_ff.use_weight) begin
                  state_ff <= ST_SCALE_SAT;
               end else begin
                  w_ff <= base_ff;
                  state_ff <= ST_TERM;
               end
            end
            ST_SCALE_SAT: begin
               w_ff <= (|scaled[63:32]) ? '1 : scaled[31:0];
               state_ff <= ST_TERM;
            end
            ST_TERM: begin
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               if (item_ff.coincident) begin
                  coinc_seen_ff <= 1'b1;
                  csum_ff <= csum_ff + term;
                  cwsum_ff <= cwsum_ff + 64'(w_ff);
               end else begin
                  vsum_ff <= vsum_ff + term;
                  wsum_ff <= wsum_ff + 64'(w_ff);
               end
               vcount_ff <= vcount_ff + 8'd1;
               state_ff <= ST_CLOSE;
            end
            ST_CLOSE: begin
               if (!item_ff.last) begin
                  state_ff <= ST_IDLE;
               end else if (sel_wsum == '0) begin
                  pend_value_ff <= '0;
                  pend_status_ff <= 1'b1;
                  state_ff <= ST_EMIT;
               end else begin
                  neg_ff <= sel_vsum[63];
                  dividend_ff <= DIV_NUM_W'(sel_mag) << FRAC_BITS;
                  divisor_ff <= sel_wsum;
                  div_start_ff <= 1'b1;
                  state_ff <= ST_FDIV;
               end
            end
            ST_FDIV: begin
               if (div_done) begin
                  pend_status_ff <= 1'b0;
                  if (neg_ff) begin
                     if (|quo[DIV_NUM_W-1:32] || (quo[31] && |quo[30:0])) begin
                        pend_value_ff <= 32'sh8000_0000;
                     end else begin
                        pend_value_ff <= $signed(32'(-quo[31:0]));
                     end
                  end else if (|quo[DIV_NUM_W-1:31]) begin
                     pend_value_ff <= 32'sh7fff_ffff;
                  end else begin
                     pend_value_ff <= $signed(quo[31:0]);
                  end
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (emit_load) begin
                  rsp_value_ff <= pend_value_ff;
                  rsp_status_ff <= pend_status_ff;
                  vsum_ff <= '0;
                  csum_ff <= '0;
                  wsum_ff <= '0;
                  cwsum_ff <= '0;
                  coinc_seen_ff <= 1'b0;
                  vcount_ff <= '0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_cell_value = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      vcount_ff <= 8'(MAX_VERTS)) else $error("vertex count beyond limit");

   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      emit_load |=> vcount_ff == '0 && !coinc_seen_ff && wsum_ff == '0)
      else $error("cell sums not cleared after result");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EMIT)
      else $error("result raised outside emit");

endmodule
